/* rtl/pdsc_pkg.sv */
package pdsc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned RES_DEPTH  = 2;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_MS = 3'd0,
    CFG_FAST_THR     = 3'd1,
    CFG_MID_THR      = 3'd2,
    CFG_SLOW_THR     = 3'd3,
    CFG_FAST_DLY     = 3'd4,
    CFG_MID_DLY      = 3'd5,
    CFG_SLOW_DLY     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]       ticks_per_ms;
    logic [DUTY_W-1:0] fast_thr;
    logic [DUTY_W-1:0] mid_thr;
    logic [DUTY_W-1:0] slow_thr;
    logic [7:0]        fast_dly;
    logic [7:0]        mid_dly;
    logic [7:0]        slow_dly;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ticks_per_ms: 16'd333,
    fast_thr:     7'd50,
    mid_thr:      7'd25,
    slow_thr:     7'd10,
    fast_dly:     8'd1,
    mid_dly:      8'd5,
    slow_dly:     8'd20
  };

  // flags that the front attaches to each tick word
  typedef struct packed {
    logic en;
    logic calc;
  } cmd_flags_t;

  typedef struct packed {
    logic [5:0]        coil;
    logic [7:0]        seg;
    logic [1:0]        level;
    logic [DUTY_W-1:0] duty;
    logic              upd;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIVIDE
  } back_state_e;

  localparam logic [5:0] COIL_SEQ [4] = '{6'h36, 6'h35, 6'h39, 6'h3A};
  localparam logic [7:0] SEG_CODE [4] = '{8'h3F, 8'h06, 8'h9B, 8'h8F};

endpackage

/* rtl/pwm_duty_stepper_speed_control.sv */
// A tick word enters the command queue at the edge that accepts it; the back end turns the
// queue head into a result word for the result ports once the result queue has room. A tick
// that ends a PWM period (falling edge after the first) first runs the bit-serial duty divider
// (one quotient bit per cycle over COUNT_WIDTH + 7 bits, then the quotient is handed over).
// Throughput: one word per cycle while the result queue has room; none while the divider runs.
// Reset (rst_ni low, asynchronous): queues empty, counters and duty zero.
module pwm_duty_stepper_speed_control #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                pwm_level_i,
  input  logic                                enable_switch_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [5:0]                          coil_pattern_o,
  output logic [7:0]                          segment_pattern_o,
  output logic [1:0]                          speed_level_o,
  output logic [pdsc_pkg::DUTY_W-1:0]         duty_percent_o,
  output logic                                duty_update_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pdsc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import pdsc_pkg::*;

  localparam int unsigned CmdW = 2 * COUNT_WIDTH + $bits(cmd_flags_t);
  localparam int unsigned ResW = $bits(result_t);

  cfg_t                   cfg_q;
  logic                   cmd_push, cmd_pop, cmd_empty;
  logic [CmdW-1:0]        cmd_wdata, cmd_rdata;
  logic                   res_push, res_full;
  result_t                res_in, res_head;
  logic [ResW-1:0]        res_rdata;
  logic                   div_start, div_done;
  logic [COUNT_WIDTH-1:0] div_high, div_period;
  logic [DUTY_W-1:0]      div_duty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TICKS_PER_MS: cfg_q.ticks_per_ms <= cfg_data_i;
        CFG_FAST_THR:     cfg_q.fast_thr     <= cfg_data_i[DUTY_W-1:0];
        CFG_MID_THR:      cfg_q.mid_thr      <= cfg_data_i[DUTY_W-1:0];
        CFG_SLOW_THR:     cfg_q.slow_thr     <= cfg_data_i[DUTY_W-1:0];
        CFG_FAST_DLY:     cfg_q.fast_dly     <= cfg_data_i[7:0];
        CFG_MID_DLY:      cfg_q.mid_dly      <= cfg_data_i[7:0];
        CFG_SLOW_DLY:     cfg_q.slow_dly     <= cfg_data_i[7:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  pdsc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .pwm_level_i    (pwm_level_i),
    .enable_switch_i(enable_switch_i),
    .cmd_push_o     (cmd_push),
    .cmd_word_o     (cmd_wdata)
  );

  pdsc_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wdata),
    .full_o (full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rdata),
    .empty_o(cmd_empty)
  );

  pdsc_divider #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .high_i  (div_high),
    .period_i(div_period),
    .done_o  (div_done),
    .duty_o  (div_duty)
  );

  pdsc_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_word_i  (cmd_rdata),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .div_start_o (div_start),
    .div_high_o  (div_high),
    .div_period_o(div_period),
    .div_done_i  (div_done),
    .div_duty_i  (div_duty)
  );

  pdsc_fifo #(
    .WIDTH(ResW),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_rdata),
    .empty_o(empty)
  );

  assign res_head          = result_t'(res_rdata);
  assign coil_pattern_o    = res_head.coil;
  assign segment_pattern_o = res_head.seg;
  assign speed_level_o     = res_head.level;
  assign duty_percent_o    = res_head.duty;
  assign duty_update_o     = res_head.upd;

endmodule

/* rtl/pdsc_fifo.sv */
module pdsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/pdsc_front.sv */
module pdsc_front #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   push_i,
  input  logic                                                   full_i,
  input  logic                                                   pwm_level_i,
  input  logic                                                   enable_switch_i,
  output logic                                                   cmd_push_o,
  output logic [2*COUNT_WIDTH+$bits(pdsc_pkg::cmd_flags_t)-1:0] cmd_word_o
);

  import pdsc_pkg::*;

  logic                   last_level_q, last_level_d;
  logic                   first_fall_q, first_fall_d;
  logic [COUNT_WIDTH-1:0] high_q, high_d, period_q, period_d;
  logic [COUNT_WIDTH-1:0] high_base, period_base;
  logic                   accept, rise, fall;
  cmd_flags_t             flags;

  assign accept = push_i && !full_i;
  assign rise   = pwm_level_i && !last_level_q;
  assign fall   = !pwm_level_i && last_level_q;

  always_comb begin
    high_base   = rise ? '0 : high_q;
    period_base = fall ? '0 : period_q;
    // saturate both counters at all ones
    period_d    = (&period_base) ? period_base : period_base + 1'b1;
    high_d      = high_base;
    if (pwm_level_i && !(&high_base)) begin
      high_d = high_base + 1'b1;
    end
    last_level_d = pwm_level_i;
    first_fall_d = first_fall_q || fall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      first_fall_q <= 1'b0;
      high_q       <= '0;
      period_q     <= '0;
    end else if (accept) begin
      last_level_q <= last_level_d;
      first_fall_q <= first_fall_d;
      high_q       <= high_d;
      period_q     <= period_d;
    end
  end

  // at a falling edge the old counts are the pulse and the period
  always_comb begin
    flags.en   = enable_switch_i;
    flags.calc = fall && first_fall_q;
  end

  assign cmd_push_o = accept;
  assign cmd_word_o = {flags, high_q, period_q};

endmodule

/* rtl/pdsc_divider.sv */
module pdsc_divider #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COUNT_WIDTH-1:0]        high_i,
  input  logic [COUNT_WIDTH-1:0]        period_i,
  output logic                          done_o,
  output logic [pdsc_pkg::DUTY_W-1:0]   duty_o
);

  import pdsc_pkg::*;

  localparam int unsigned NumW = COUNT_WIDTH + DUTY_W;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0]        num_q, num_d, num_start;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d, div_q;
  logic [COUNT_WIDTH:0]   rem_shift;
  logic [COUNT_WIDTH+1:0] diff;
  logic [CntW-1:0]        cnt_q;
  logic                   done_q, zero_q, q_bit, over;

  // high * 100 as shifted adds
  assign num_start = (NumW'(high_i) << 6) + (NumW'(high_i) << 5) + (NumW'(high_i) << 2);

  always_comb begin
    rem_shift = {rem_q, num_q[NumW-1]};
    diff      = {1'b0, rem_shift} - {2'b0, div_q};
    q_bit     = !diff[COUNT_WIDTH+1];
    rem_d     = q_bit ? diff[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
    num_d     = {num_q[NumW-2:0], q_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(NumW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_start;
      rem_q  <= '0;
      div_q  <= period_i;
      zero_q <= (period_i == '0);
    end else if (cnt_q != '0) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // clamp the quotient to 100; a zero period gives zero
  assign over   = (|num_q[NumW-1:DUTY_W]) || (num_q[DUTY_W-1:0] > DUTY_MAX);
  assign duty_o = zero_q ? '0 : (over ? DUTY_MAX : num_q[DUTY_W-1:0]);
  assign done_o = done_q;

endmodule

/* rtl/pdsc_back.sv */
module pdsc_back #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  pdsc_pkg::cfg_t                                         cfg_i,
  input  logic [2*COUNT_WIDTH+$bits(pdsc_pkg::cmd_flags_t)-1:0] cmd_word_i,
  input  logic                                                   cmd_empty_i,
  output logic                                                   cmd_pop_o,
  input  logic                                                   res_full_i,
  output logic                                                   res_push_o,
  output pdsc_pkg::result_t                                      res_o,
  output logic                                                   div_start_o,
  output logic [COUNT_WIDTH-1:0]                                 div_high_o,
  output logic [COUNT_WIDTH-1:0]                                 div_period_o,
  input  logic                                                   div_done_i,
  input  logic [pdsc_pkg::DUTY_W-1:0]                            div_duty_i
);

  import pdsc_pkg::*;

  localparam int unsigned CmdW = 2 * COUNT_WIDTH + $bits(cmd_flags_t);

  back_state_e       state_q, state_d;
  cmd_flags_t        flags;
  logic              ready, fin;
  logic [DUTY_W-1:0] duty_q, duty_new;
  logic [1:0]        phase_q, phase_d, level, shown;
  logic [15:0]       tick_q, tick_d, tick_inc;
  logic [7:0]        ms_q, ms_d, ms_inc, delay;
  logic [5:0]        coil;

  assign flags        = cmd_word_i[CmdW-1 -: $bits(cmd_flags_t)];
  assign div_high_o   = cmd_word_i[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign div_period_o = cmd_word_i[COUNT_WIDTH-1:0];
  assign ready        = !cmd_empty_i && !res_full_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (ready && flags.calc) begin
          state_d = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (div_done_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    div_start_o = 1'b0;
    fin         = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (ready) begin
          div_start_o = flags.calc;
          fin         = !flags.calc;
        end
      end
      BK_DIVIDE: begin
        // head word stays queued until the quotient is in
        fin = div_done_i;
      end
      default: begin
        div_start_o = 1'b0;
        fin         = 1'b0;
      end
    endcase
  end

  assign cmd_pop_o  = fin;
  assign res_push_o = fin;

  always_comb begin
    duty_new = flags.calc ? div_duty_i : duty_q;
    if (duty_new >= cfg_i.fast_thr) begin
      level = 2'd3;
    end else if (duty_new >= cfg_i.mid_thr) begin
      level = 2'd2;
    end else if (duty_new >= cfg_i.slow_thr) begin
      level = 2'd1;
    end else begin
      level = 2'd0;
    end
    shown = flags.en ? level : 2'd0;

    case (shown)
      2'd3:    delay = cfg_i.fast_dly;
      2'd2:    delay = cfg_i.mid_dly;
      default: delay = cfg_i.slow_dly;
    endcase

    tick_inc = tick_q + 1'b1;
    ms_inc   = ms_q + 1'b1;
    coil     = '0;
    phase_d  = '0;
    tick_d   = '0;
    ms_d     = '0;
    if (shown != 2'd0) begin
      coil    = COIL_SEQ[phase_q];
      phase_d = phase_q;
      ms_d    = ms_q;
      tick_d  = tick_inc;
      // a zero limit counts as one
      if (tick_inc >= cfg_i.ticks_per_ms || tick_inc == '0) begin
        tick_d = '0;
        ms_d   = ms_inc;
        if (ms_inc >= delay || ms_inc == '0) begin
          ms_d    = '0;
          phase_d = phase_q + 1'b1;
        end
      end
    end

    res_o.coil  = coil;
    res_o.seg   = SEG_CODE[shown];
    res_o.level = shown;
    res_o.duty  = duty_new;
    res_o.upd   = flags.calc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      duty_q  <= '0;
      phase_q <= '0;
      tick_q  <= '0;
      ms_q    <= '0;
    end else begin
      state_q <= state_d;
      if (fin) begin
        duty_q  <= duty_new;
        phase_q <= phase_d;
        tick_q  <= tick_d;
        ms_q    <= ms_d;
      end
    end
  end

endmodule

/* rtl/pdsc_checker.sv */
module pdsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            empty,
  input logic                            pop,
  input logic [5:0]                      coil_pattern_o,
  input logic [7:0]                      segment_pattern_o,
  input logic [1:0]                      speed_level_o,
  input logic [pdsc_pkg::DUTY_W-1:0]     duty_percent_o
);

  import pdsc_pkg::*;

  // stopped words drive no coil
  a_stopped_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && speed_level_o == 2'd0) |-> coil_pattern_o == 6'd0)
    else $error("coils driven at speed level zero");

  a_segment_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> segment_pattern_o == SEG_CODE[speed_level_o])
    else $error("segment code does not match speed level");

  a_running_coil_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && speed_level_o != 2'd0) |->
      (coil_pattern_o == COIL_SEQ[0] || coil_pattern_o == COIL_SEQ[1] ||
       coil_pattern_o == COIL_SEQ[2] || coil_pattern_o == COIL_SEQ[3]))
    else $error("running coil word is not a phase pattern");

  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> duty_percent_o <= DUTY_MAX)
    else $error("duty above 100 percent");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(duty_percent_o) && $stable(coil_pattern_o)))
    else $error("result word changed while waiting");

endmodule

bind pwm_duty_stepper_speed_control pdsc_checker u_pdsc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .coil_pattern_o   (coil_pattern_o),
  .segment_pattern_o(segment_pattern_o),
  .speed_level_o    (speed_level_o),
  .duty_percent_o   (duty_percent_o)
);

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pdsc_pkg::*;

  localparam int unsigned COUNT_W = 24;
  localparam int unsigned SETTLE_CYCLES = COUNT_W + 12;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned CHUNK_TICKS = 155;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  class drive_scoreboard;
    cfg_t                 cfg;
    logic                 last_pwm;
    logic [COUNT_W-1:0]   high_cnt;
    logic [COUNT_W-1:0]   period_cnt;
    bit                   seen_fall;
    logic [DUTY_W-1:0]    duty;
    logic [1:0]           phase;
    logic [15:0]          tick_cnt;
    logic [7:0]           ms_cnt;
    result_t              drive_q[$];
    int                   errors;

    function new();
      cfg        = CFG_RESET;
      last_pwm   = 1'b0;
      high_cnt   = '0;
      period_cnt = '0;
      seen_fall  = 1'b0;
      duty       = '0;
      phase      = '0;
      tick_cnt   = '0;
      ms_cnt     = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TICKS_PER_MS: cfg.ticks_per_ms = data;
        CFG_FAST_THR:     cfg.fast_thr = data[DUTY_W-1:0];
        CFG_MID_THR:      cfg.mid_thr = data[DUTY_W-1:0];
        CFG_SLOW_THR:     cfg.slow_thr = data[DUTY_W-1:0];
        CFG_FAST_DLY:     cfg.fast_dly = data[7:0];
        CFG_MID_DLY:      cfg.mid_dly = data[7:0];
        CFG_SLOW_DLY:     cfg.slow_dly = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [5:0] coil_for(logic [1:0] ph);
      return COIL_SEQ[ph];
    endfunction

    function logic [7:0] segments_for(logic [1:0] lvl);
      return SEG_CODE[lvl];
    endfunction

    function logic [1:0] band_of(logic [DUTY_W-1:0] d);
      if (d >= cfg.fast_thr) return 2'd3;
      if (d >= cfg.mid_thr) return 2'd2;
      if (d >= cfg.slow_thr) return 2'd1;
      return 2'd0;
    endfunction

    function void note_tick(logic pwm, logic en);
      result_t           word;
      longint unsigned   q;
      logic [1:0]        shown;
      logic [7:0]        delay;
      word = '0;
      if (pwm && !last_pwm) high_cnt = '0;
      if (!pwm && last_pwm) begin
        if (seen_fall) begin
          if (period_cnt == '0) begin
            duty = '0;
          end else begin
            q = (64'(high_cnt) * 64'd100) / 64'(period_cnt);
            duty = (q > 64'd100) ? DUTY_MAX : DUTY_W'(q);
          end
          word.upd = 1'b1;
        end
        seen_fall = 1'b1;
        period_cnt = '0;
      end
      // both counters saturate instead of wrapping
      if (period_cnt != '1) period_cnt = period_cnt + 1'b1;
      if (pwm && high_cnt != '1) high_cnt = high_cnt + 1'b1;
      last_pwm = pwm;

      shown = en ? band_of(duty) : 2'd0;
      if (shown == 2'd0) begin
        word.coil = '0;
        phase = '0;
        tick_cnt = '0;
        ms_cnt = '0;
      end else begin
        delay = (shown == 2'd3) ? cfg.fast_dly : (shown == 2'd2) ? cfg.mid_dly : cfg.slow_dly;
        word.coil = coil_for(phase);
        tick_cnt = tick_cnt + 1'b1;
        // a zero tick count or zero delay acts as one
        if (tick_cnt >= cfg.ticks_per_ms || tick_cnt == '0) begin
          tick_cnt = '0;
          ms_cnt = ms_cnt + 1'b1;
          if (ms_cnt >= delay || ms_cnt == '0) begin
            ms_cnt = '0;
            phase = phase + 1'b1;
          end
        end
      end
      word.seg = segments_for(shown);
      word.level = shown;
      word.duty = duty;
      drive_q.push_back(word);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = drive_q.pop_front();
      if (got.coil !== want.coil) begin
        $display("%0t: coil_pattern expected %h actual %h", $time, want.coil, got.coil);
        errors++;
      end
      if (got.seg !== want.seg) begin
        $display("%0t: segment_pattern expected %h actual %h", $time, want.seg, got.seg);
        errors++;
      end
      if (got.level !== want.level) begin
        $display("%0t: speed_level expected %0d actual %0d", $time, want.level, got.level);
        errors++;
      end
      if (got.duty !== want.duty) begin
        $display("%0t: duty_percent expected %0d actual %0d", $time, want.duty, got.duty);
        errors++;
      end
      if (got.upd !== want.upd) begin
        $display("%0t: duty_update expected %0d actual %0d", $time, want.upd, got.upd);
        errors++;
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  pwm_level_i = 1'b0;
  logic                  enable_switch_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [5:0]            coil_pattern_o;
  logic [7:0]            segment_pattern_o;
  logic [1:0]            speed_level_o;
  logic [DUTY_W-1:0]     duty_percent_o;
  logic                  duty_update_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  drive_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     cycles = 0;

  pwm_duty_stepper_speed_control #(
    .COUNT_WIDTH(COUNT_W)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .pwm_level_i       (pwm_level_i),
    .enable_switch_i   (enable_switch_i),
    .empty             (empty),
    .pop               (pop),
    .coil_pattern_o    (coil_pattern_o),
    .segment_pattern_o (segment_pattern_o),
    .speed_level_o     (speed_level_o),
    .duty_percent_o    (duty_percent_o),
    .duty_update_o     (duty_update_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: check each popped word, then pick next cycle's pop
  initial begin
    result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        got.coil  = coil_pattern_o;
        got.seg   = segment_pattern_o;
        got.level = speed_level_o;
        got.duty  = duty_percent_o;
        got.upd   = duty_update_o;
        sb.check_word(got);
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_tick(input logic pwm, input logic en, input bit drain_first);
    if (drain_first || $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while (drain_first && sb.pending() != 0) @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    push <= 1'b1;
    pwm_level_i <= pwm;
    enable_switch_i <= en;
    do @(posedge clk_i); while (full);
    sb.note_tick(pwm, en);
  endtask

  task automatic wait_quiet();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] tpm, input logic [6:0] fthr, input logic [6:0] mthr,
                           input logic [6:0] sthr, input logic [7:0] fdly,
                           input logic [7:0] mdly, input logic [7:0] sdly,
                           input bit poke_spare);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    for (int r = 0; r < 8; r++) begin
      // upper bits carry junk so that the field masking is exercised
      case (r)
        0: begin idx = CFG_TICKS_PER_MS; data = tpm; end
        1: begin idx = CFG_FAST_THR; data = {9'($urandom), fthr}; end
        2: begin idx = CFG_MID_THR; data = {9'($urandom), mthr}; end
        3: begin idx = CFG_SLOW_THR; data = {9'($urandom), sthr}; end
        4: begin idx = CFG_FAST_DLY; data = {8'($urandom), fdly}; end
        5: begin idx = CFG_MID_DLY; data = {8'($urandom), mdly}; end
        6: begin idx = CFG_SLOW_DLY; data = {8'($urandom), sdly}; end
        default: begin idx = CFG_SPARE_IDX; data = 16'($urandom); end
      endcase
      if (r < 7 || poke_spare) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= idx;
        cfg_data_i <= data;
        do @(posedge clk_i); while (!cfg_ready_o);
        sb.write_reg(idx, data);
      end
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly whole PWM pulses of random shape, some single-tick noise
  task automatic run_waveform(input int unsigned n_ticks);
    int unsigned sent;
    int unsigned drain_at;
    int unsigned mode;
    int unsigned hi;
    int unsigned lo;
    logic        en;
    sent = 0;
    drain_at = $urandom_range(n_ticks - 1);
    while (sent < n_ticks) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        send_tick(1'($urandom), 1'($urandom), sent == drain_at);
        sent++;
      end else begin
        // long low after a short pulse drives the duty down to zero or one percent
        hi = (mode == 1) ? $urandom_range(1, 2) : $urandom_range(1, 20);
        lo = (mode == 1) ? $urandom_range(100, 220) : $urandom_range(1, 20);
        en = ($urandom_range(9) != 0);
        for (int unsigned k = 0; k < hi + lo; k++) begin
          send_tick(k < hi, en, sent == drain_at);
          sent++;
        end
      end
    end
  endtask

  initial begin
    bit [0:24] dir_pwm;
    bit [0:24] dir_en;
    dir_pwm = 25'b0110111001001000000001010;
    dir_en  = 25'b0111111111100011111111111;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 88;
    // first fall, high and low duty bands, switch off and back on
    for (int i = 0; i < 25; i++) send_tick(dir_pwm[i], dir_en[i], 1'b0);
    wait_quiet();

    configure(16'd0, 7'd50, 7'd25, 7'd10, 8'd1, 8'd2, 8'd3, 1'b1);
    run_waveform(CHUNK_TICKS);
    wait_quiet();

    configure(16'd2, 7'd0, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    run_waveform(CHUNK_TICKS);
    wait_quiet();

    send_idle_pct = 88;
    recv_idle_pct = 28;
    configure(16'hFFFF, 7'd127, 7'd127, 7'd127, 8'd255, 8'd255, 8'd255, 1'b0);
    run_waveform(CHUNK_TICKS);
    wait_quiet();

    configure(16'd1, 7'd80, 7'd40, 7'd5, 8'd3, 8'd255, 8'd1, 1'b0);
    run_waveform(CHUNK_TICKS);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(16'($urandom_range(1, 4)), 7'($urandom_range(100)), 7'($urandom_range(100)),
              7'($urandom_range(100)), 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
              8'($urandom_range(1, 4)), 1'b0);
    run_waveform(CHUNK_TICKS);
    wait_quiet();

    configure(16'd3, 7'd100, 7'd60, 7'd1, 8'd2, 8'd1, 8'd4, 1'b0);
    run_waveform(CHUNK_TICKS);
    wait_quiet();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
